### sv/tfc_pkg.sv
// Package for the TDC fine-time calibration table.
// Holds the sizes, the mode codes, the fixed-point constants and the stage struct.
// No dependencies.
`default_nettype none

package tfc_pkg;

   // Table geometry
   localparam int CHANNELS          = 16;
   localparam int SLOTS_PER_CHANNEL = 4 * 2;
   localparam int SLOTS             = CHANNELS * SLOTS_PER_CHANNEL;
   localparam int SLOT_W            = $clog2(SLOTS);
   localparam int FINE_ENTRIES      = 1024;
   localparam int CODE_W            = $clog2(FINE_ENTRIES);
   localparam int FINE_DEPTH        = SLOTS * FINE_ENTRIES;
   localparam int FINE_ADDR_W       = $clog2(FINE_DEPTH);

   // Field widths
   localparam int MODE_W    = 3;
   localparam int CHANNEL_W = 4;
   localparam int TAC_W     = 2;
   localparam int FCODE_W   = 12;
   localparam int COARSE_W  = 10;
   localparam int WVAL_W    = 32;
   localparam int ENTRY_W   = 16;
   localparam int OFFSET_W  = 32;
   localparam int RESULT_W  = 40;
   localparam int FRAC_W    = 12;

   // Q.12 constants
   localparam int ONE_Q12      = 1 << FRAC_W;
   localparam int SPLIT_Q12    = (ONE_Q12 * 5) / 2;
   localparam int LOW_Q12      = ONE_Q12;
   localparam int HIGH_Q12     = 3 * ONE_Q12;
   localparam int ENTRY_MAX    = (1 << (ENTRY_W - 1)) - 1;
   localparam int ENTRY_MIN    = -(1 << (ENTRY_W - 1));

   // Integer parts added to the coarse count in the time formula
   localparam int K_EVEN_LOW  = 2;
   localparam int K_EVEN_HIGH = 4;
   localparam int K_ODD       = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_WR_ENTRY  = 3'd0,
      MODE_WR_OFFSET = 3'd1,
      MODE_RD_ENTRY  = 3'd2,
      MODE_RD_OFFSET = 3'd3,
      MODE_TIME      = 3'd4
   } mode_type;

   // Operation carried to the result stage
   typedef enum logic [1:0] {
      OP_NONE,
      OP_RD_ENTRY,
      OP_RD_OFFSET,
      OP_TIME
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [COARSE_W-1:0] coarse;
      logic                off_valid;
   } stage_type;

endpackage

`default_nettype wire

### sv/tfc_req_if.sv
// Request channel of the calibration table: valid/ready plus the item fields.
// Depends on tfc_pkg.
`default_nettype none

interface tfc_req_if
   import tfc_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [CHANNEL_W-1:0]       channel;
   logic [TAC_W-1:0]           tac;
   logic                       side;
   logic [FCODE_W-1:0]         fine_code;
   logic [COARSE_W-1:0]        coarse;
   logic signed [WVAL_W-1:0]   write_value;

   modport source (output valid, mode, channel, tac, side, fine_code, coarse, write_value,
                   input ready);
   modport sink   (input valid, mode, channel, tac, side, fine_code, coarse, write_value,
                   output ready);
endinterface

`default_nettype wire

### sv/tfc_rsp_if.sv
// Result channel of the calibration table: valid/ready plus the result fields.
// Depends on tfc_pkg.
`default_nettype none

interface tfc_rsp_if
   import tfc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [RESULT_W-1:0]  read_value;
   logic                        in_range;

   modport source (output valid, read_value, in_range, input ready);
   modport sink   (input valid, read_value, in_range, output ready);
endinterface

`default_nettype wire

### sv/tdc_fine_time_calibration_lut.sv
// TDC fine-time calibration table, top level.
// A request passes through the memory read and stage registers, then the result register.
// Throughput: one request per cycle while the result side takes results, set by the single read port of each memory.
// Reset clears the pipeline valids and the offset valid bits, so every offset reads as zero;
// fine entries hold no reset value and must be written before they are read.
`default_nettype none

module tdc_fine_time_calibration_lut
   import tfc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tfc_req_if.sink   req_chan,
   tfc_rsp_if.source rsp_chan
);

   logic                stage_valid;
   logic                stage_move;
   stage_type           stage;
   logic [ENTRY_W-1:0]  fine_q;
   logic [OFFSET_W-1:0] offset_q;

   tfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .stage_move  (stage_move),
      .stage_valid (stage_valid),
      .stage       (stage),
      .fine_q      (fine_q),
      .offset_q    (offset_q)
   );

   tfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .fine_q      (fine_q),
      .offset_q    (offset_q),
      .stage_move  (stage_move),
      .rsp         (rsp_chan)
   );

endmodule

`default_nettype wire

### sv/tfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/tfc_front.sv
// Input stage: decodes the request, forms slot and entry addresses, performs
// writes and issues reads to the fine and offset memories. Depends on tfc_pkg, tfc_ram.
`default_nettype none

module tfc_front
   import tfc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   tfc_req_if.sink                 req,
   input  wire logic               stage_move,
   output      logic               stage_valid,
   output      stage_type          stage,
   output      logic [ENTRY_W-1:0] fine_q,
   output      logic [OFFSET_W-1:0] offset_q
);

   logic                   stage_valid_ff;
   stage_type              stage_ff;
   stage_type              stage_in;
   logic                   off_valid_ff [SLOTS];
   logic                   accept;
   logic                   chan_ok;
   logic [SLOT_W-1:0]      slot;
   logic [CODE_W-1:0]      code_clamped;
   logic [FINE_ADDR_W-1:0] entry_addr;
   logic                   wr_entry;
   logic                   wr_offset;
   logic [ENTRY_W-1:0]     entry_sat;
   op_type                 op;

   // Take a new request when the stage is empty or moving on
   assign req.ready = !stage_valid_ff || stage_move;
   assign accept    = req.valid && req.ready;

   // Address formation
   always_comb begin
      chan_ok = (32'(req.channel) < CHANNELS);
      slot    = SLOT_W'({req.channel, req.tac, req.side});
      if (32'(req.fine_code) >= FINE_ENTRIES) begin
         code_clamped = CODE_W'(FINE_ENTRIES - 1);
      end else begin
         code_clamped = CODE_W'(req.fine_code);
      end
      entry_addr = FINE_ADDR_W'(FINE_ADDR_W'(slot) * FINE_ADDR_W'(FINE_ENTRIES))
                   + FINE_ADDR_W'(code_clamped);
   end

   // Saturate the write value to the entry width
   always_comb begin
      if (req.write_value > WVAL_W'(ENTRY_MAX)) begin
         entry_sat = ENTRY_W'(ENTRY_MAX);
      end else if (req.write_value < WVAL_W'(ENTRY_MIN)) begin
         entry_sat = ENTRY_W'(ENTRY_MIN);
      end else begin
         entry_sat = req.write_value[ENTRY_W-1:0];
      end
   end

   // Decode the mode
   always_comb begin
      wr_entry  = 1'b0;
      wr_offset = 1'b0;
      op        = OP_NONE;
      unique case (req.mode)
         MODE_WR_ENTRY:  wr_entry  = chan_ok;
         MODE_WR_OFFSET: wr_offset = chan_ok;
         MODE_RD_ENTRY:  op        = chan_ok ? OP_RD_ENTRY : OP_NONE;
         MODE_RD_OFFSET: op        = chan_ok ? OP_RD_OFFSET : OP_NONE;
         MODE_TIME:      op        = chan_ok ? OP_TIME : OP_NONE;
         default:        op        = OP_NONE;
      endcase
      stage_in.op        = op;
      stage_in.coarse    = req.coarse;
      stage_in.off_valid = off_valid_ff[slot];
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (accept) begin
         stage_valid_ff <= 1'b1;
      end else if (stage_move) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   // Offset valid bits: an unwritten offset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            off_valid_ff[i] <= 1'b0;
         end
      end else if (accept && wr_offset) begin
         off_valid_ff[slot] <= 1'b1;
      end
   end

   tfc_ram #(.WIDTH(ENTRY_W), .DEPTH(FINE_DEPTH)) u_fine_ram (
      .clock   (clock),
      .wr_en   (accept && wr_entry),
      .wr_addr (entry_addr),
      .wr_data (entry_sat),
      .rd_en   (accept),
      .rd_addr (entry_addr),
      .rd_data (fine_q)
   );

   tfc_ram #(.WIDTH(OFFSET_W), .DEPTH(SLOTS)) u_offset_ram (
      .clock   (clock),
      .wr_en   (accept && wr_offset),
      .wr_addr (slot),
      .wr_data (OFFSET_W'(req.write_value)),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (offset_q)
   );

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

`default_nettype wire

### sv/tfc_back.sv
// Result stage: forms the read value or the calibrated time and holds it in the
// output register until transferred. Depends on tfc_pkg.
`default_nettype none

module tfc_back
   import tfc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                stage_valid,
   input  wire stage_type           stage,
   input  wire logic [ENTRY_W-1:0]  fine_q,
   input  wire logic [OFFSET_W-1:0] offset_q,
   output      logic                stage_move,
   tfc_rsp_if.source                rsp
);

   logic                       rsp_valid_ff;
   logic signed [RESULT_W-1:0] value_ff;
   logic signed [RESULT_W-1:0] value_in;
   logic                       range_ff;
   logic                       range_in;
   logic signed [ENTRY_W-1:0]  q;
   logic signed [OFFSET_W-1:0] offset;
   logic [COARSE_W:0]          base_int;
   logic [2:0]                 k_int;

   // Move on when the output register is free or being emptied
   assign stage_move = stage_valid && (!rsp_valid_ff || rsp.ready);

   // Compute the result
   always_comb begin
      q        = signed'(fine_q);
      offset   = stage.off_valid ? signed'(offset_q) : '0;
      if (stage.coarse[0]) begin
         k_int = 3'(K_ODD);
      end else if (q < ENTRY_W'(SPLIT_Q12)) begin
         k_int = 3'(K_EVEN_LOW);
      end else begin
         k_int = 3'(K_EVEN_HIGH);
      end
      base_int = (COARSE_W+1)'(stage.coarse) + (COARSE_W+1)'(k_int);
      value_in = '0;
      range_in = 1'b0;
      case (stage.op)
         OP_RD_ENTRY:  value_in = RESULT_W'(q);
         OP_RD_OFFSET: value_in = RESULT_W'(offset);
         OP_TIME: begin
            value_in = signed'(RESULT_W'({base_int, {FRAC_W{1'b0}}}))
                       + RESULT_W'(offset) - RESULT_W'(q);
            range_in = (q >= ENTRY_W'(LOW_Q12)) && (q <= ENTRY_W'(HIGH_Q12));
         end
         default: begin
            value_in = '0;
            range_in = 1'b0;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         value_ff <= value_in;
         range_ff <= range_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = value_ff;
   assign rsp.in_range   = range_ff;

endmodule

`default_nettype wire

### tb/tdc_fine_time_calibration_lut_test.sv
// Self-checking testbench for the TDC fine-time calibration table.
// Drives tfc_req_if, checks tfc_rsp_if against an in-bench shadow of both tables.
// Depends on tfc_pkg, tfc_req_if, tfc_rsp_if and tdc_fine_time_calibration_lut.
`timescale 1ns / 100ps

module tdc_fine_time_calibration_lut_test;
   import tfc_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int MAX_GAP        = 18;
   localparam int LONG_HOLD      = 150;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ROW_COUNT      = 26;

   // Mode codes the block does not decode
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic signed [WVAL_W-1:0] WVAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WVAL_W-1:0] WVAL_MIN = 32'sh8000_0000;
   localparam logic signed [RESULT_W-1:0] NO_VALUE = '0;

   // Entry values around the decision points of the time formula and the entry limits
   localparam int EDGE_Q [12] = '{LOW_Q12 - 1, LOW_Q12, SPLIT_Q12 - 1, SPLIT_Q12,
                                  HIGH_Q12, HIGH_Q12 + 1, 0, -1, ENTRY_MAX, ENTRY_MIN,
                                  ENTRY_MAX + 1, ENTRY_MIN - 1};

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [CHANNEL_W-1:0]       channel;
      logic [TAC_W-1:0]           tac;
      logic                       side;
      logic [FCODE_W-1:0]         fine_code;
      logic [COARSE_W-1:0]        coarse;
      logic signed [WVAL_W-1:0]   write_value;
      logic                       has_fixed;
      logic signed [RESULT_W-1:0] fixed_value;
   } tdc_request_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] read_value;
      logic                       in_range;
   } tdc_result_type;

   // Directed rows: mode, channel, tac, side, code, coarse, write value, typed result
   localparam tdc_request_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{MODE_RD_OFFSET, 4'd0,  2'd0, 1'b0, 12'd0,    10'd0,    32'sd0,   1'b1, NO_VALUE},
      '{MODE_RD_OFFSET, 4'd15, 2'd3, 1'b1, 12'd0,    10'd0,    32'sd0,   1'b1, NO_VALUE},
      '{MODE_WR_ENTRY,  4'd0,  2'd0, 1'b0, 12'd0,    10'd0,    WVAL_MAX, 1'b1, NO_VALUE},
      '{MODE_RD_ENTRY,  4'd0,  2'd0, 1'b0, 12'd0,    10'd0,    32'sd0,   1'b1,
        RESULT_W'(ENTRY_MAX)},
      '{MODE_WR_ENTRY,  4'd15, 2'd3, 1'b1, 12'hFFF,  10'd0,    WVAL_MIN, 1'b1, NO_VALUE},
      '{MODE_RD_ENTRY,  4'd15, 2'd3, 1'b1, 12'h3FF,  10'd0,    32'sd0,   1'b1,
        RESULT_W'(ENTRY_MIN)},
      '{MODE_RD_ENTRY,  4'd15, 2'd3, 1'b1, 12'h800,  10'd0,    32'sd0,   1'b1,
        RESULT_W'(ENTRY_MIN)},
      '{MODE_WR_OFFSET, 4'd0,  2'd0, 1'b0, 12'd0,    10'd0,    WVAL_MAX, 1'b1, NO_VALUE},
      '{MODE_RD_OFFSET, 4'd0,  2'd0, 1'b0, 12'd0,    10'd0,    32'sd0,   1'b1,
        RESULT_W'(WVAL_MAX)},
      '{MODE_WR_OFFSET, 4'd15, 2'd3, 1'b1, 12'd0,    10'd0,    WVAL_MIN, 1'b1, NO_VALUE},
      '{MODE_RD_OFFSET, 4'd15, 2'd3, 1'b1, 12'd0,    10'd0,    32'sd0,   1'b1,
        RESULT_W'(WVAL_MIN)},
      '{MODE_TIME,      4'd0,  2'd0, 1'b0, 12'd0,    10'd1023, 32'sd0,   1'b0, NO_VALUE},
      '{MODE_TIME,      4'd15, 2'd3, 1'b1, 12'hFFF,  10'd1022, 32'sd0,   1'b0, NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd100,  10'd0, WVAL_W'(SPLIT_Q12 - 1), 1'b1,
        NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd101,  10'd0, WVAL_W'(SPLIT_Q12), 1'b1, NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd102,  10'd0, WVAL_W'(LOW_Q12 - 1), 1'b1,
        NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd103,  10'd0, WVAL_W'(LOW_Q12), 1'b1, NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd104,  10'd0, WVAL_W'(HIGH_Q12), 1'b1, NO_VALUE},
      '{MODE_WR_ENTRY,  4'd3,  2'd1, 1'b0, 12'd105,  10'd0, WVAL_W'(HIGH_Q12 + 1), 1'b1,
        NO_VALUE},
      '{MODE_TIME,      4'd3,  2'd1, 1'b0, 12'd100,  10'd0,    32'sd0,   1'b0, NO_VALUE},
      '{MODE_TIME,      4'd3,  2'd1, 1'b0, 12'd101,  10'd2,    32'sd0,   1'b0, NO_VALUE},
      '{MODE_TIME,      4'd3,  2'd1, 1'b0, 12'd102,  10'd5,    32'sd0,   1'b0, NO_VALUE},
      '{MODE_TIME,      4'd3,  2'd1, 1'b0, 12'd103,  10'd6,    32'sd0,   1'b0, NO_VALUE},
      '{MODE_TIME,      4'd3,  2'd1, 1'b0, 12'd104,  10'd7,    32'sd0,   1'b0, NO_VALUE},
      '{MODE_SPARE_FIRST, 4'd5, 2'd2, 1'b1, 12'hABC, 10'd9,    WVAL_MAX, 1'b1, NO_VALUE},
      '{MODE_SPARE_LAST,  4'd9, 2'd1, 1'b0, 12'h123, 10'd10,   WVAL_MIN, 1'b1, NO_VALUE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfc_req_if req_chan ();
   tfc_rsp_if rsp_chan ();

   tdc_fine_time_calibration_lut dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copies of the two tables
   logic signed [ENTRY_W-1:0]  entry_store  [FINE_DEPTH];
   logic signed [OFFSET_W-1:0] offset_store [SLOTS];

   // Entries already scheduled for a write, so reads never hit an unwritten one
   bit entry_written [FINE_DEPTH];
   int written_keys [$];

   tdc_request_type requests_in_flight [$];
   tdc_result_type  expected_results [$];

   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int rsp_hold_cycles = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int mode_counts [8];
   int clamped_codes = 0;
   int times_in_range = 0;

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic int draw_gap(input bit idle);
      return idle ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   function automatic int entry_index(input tdc_request_type r);
      int code;
      code = (r.fine_code >= FINE_ENTRIES) ? FINE_ENTRIES - 1 : int'(r.fine_code);
      return int'({r.channel, r.tac, r.side}) * FINE_ENTRIES + code;
   endfunction

   // Apply one request to the shadow tables and return the result it must produce
   function automatic tdc_result_type compute_lookup_result(input tdc_request_type r);
      tdc_result_type res;
      int slot;
      int key;
      longint wval;
      longint q;
      longint f;
      longint t;
      res = '0;
      slot = int'({r.channel, r.tac, r.side});
      key = entry_index(r);
      wval = $signed(r.write_value);
      if (int'(r.channel) < CHANNELS) begin
         case (r.mode)
            MODE_WR_ENTRY: begin
               if (wval > ENTRY_MAX) begin
                  entry_store[key] = ENTRY_W'(ENTRY_MAX);
               end else if (wval < ENTRY_MIN) begin
                  entry_store[key] = ENTRY_W'(ENTRY_MIN);
               end else begin
                  entry_store[key] = r.write_value[ENTRY_W-1:0];
               end
            end
            MODE_WR_OFFSET: offset_store[slot] = r.write_value;
            MODE_RD_ENTRY:  res.read_value = RESULT_W'(entry_store[key]);
            MODE_RD_OFFSET: res.read_value = RESULT_W'(offset_store[slot]);
            MODE_TIME: begin
               q = entry_store[key];
               if (!r.coarse[0]) begin
                  f = (q < SPLIT_Q12) ? K_EVEN_LOW * ONE_Q12 - q : K_EVEN_HIGH * ONE_Q12 - q;
               end else begin
                  f = K_ODD * ONE_Q12 - q;
               end
               t = longint'(r.coarse) * ONE_Q12 + f + longint'(offset_store[slot]);
               res.read_value = t[RESULT_W-1:0];
               res.in_range = (q >= LOW_Q12) && (q <= HIGH_Q12);
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Draw a random request; entry reads and lookups only target entries already written
   function automatic tdc_request_type make_random_request();
      tdc_request_type r;
      int roll;
      int key;
      r = '0;
      r.coarse = COARSE_W'($urandom_range(0, 1023));
      r.fine_code = FCODE_W'($urandom_range(0, 4095));
      r.write_value = $urandom;
      {r.channel, r.tac, r.side} = SLOT_W'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (written_keys.size() == 0 && ((roll >= 33 && roll < 48) || (roll >= 55 && roll < 95)))
         roll = 0;
      if (roll < 25) begin
         r.mode = MODE_WR_ENTRY;
         if ($urandom_range(0, 3) != 0)
            r.fine_code = FCODE_W'($urandom_range(0, FINE_ENTRIES - 1));
         case ($urandom_range(0, 4))
            0, 1:    r.write_value = $urandom_range(0, 4 * ONE_Q12);
            2:       r.write_value = EDGE_Q[$urandom_range(0, 11)];
            3:       r.write_value = WVAL_W'($signed(ENTRY_W'($urandom)));
            default: r.write_value = $urandom;
         endcase
      end else if (roll < 33) begin
         r.mode = MODE_WR_OFFSET;
         if ($urandom_range(0, 1) != 0)
            r.write_value = WVAL_W'($signed(21'($urandom)));
      end else if (roll < 55 && roll >= 48) begin
         r.mode = MODE_RD_OFFSET;
      end else if (roll < 95) begin
         r.mode = (roll < 48) ? MODE_RD_ENTRY : MODE_TIME;
         key = written_keys[$urandom_range(0, written_keys.size() - 1)];
         {r.channel, r.tac, r.side} = SLOT_W'(key / FINE_ENTRIES);
         r.fine_code = FCODE_W'(key % FINE_ENTRIES);
         // The top entry is also reached by any clamped code
         if (r.fine_code == FINE_ENTRIES - 1 && $urandom_range(0, 1) != 0)
            r.fine_code = FCODE_W'($urandom_range(FINE_ENTRIES - 1, 4095));
      end else begin
         r.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      return r;
   endfunction

   // Present one request and hold it until the transfer
   task automatic drive_request(input tdc_request_type r);
      int gap;
      gap = draw_gap(send_idle);
      if (r.mode == MODE_WR_ENTRY && int'(r.channel) < CHANNELS &&
          !entry_written[entry_index(r)]) begin
         entry_written[entry_index(r)] = 1'b1;
         written_keys.push_back(entry_index(r));
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      requests_in_flight.push_back(r);
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= r.mode;
      req_chan.channel     <= r.channel;
      req_chan.tac         <= r.tac;
      req_chan.side        <= r.side;
      req_chan.fine_code   <= r.fine_code;
      req_chan.coarse      <= r.coarse;
      req_chan.write_value <= r.write_value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait until every result has been taken
   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      while (requests_in_flight.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold on request
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = draw_gap(recv_idle);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Predict on each request transfer, check on each result transfer
   always @(posedge clock) begin
      tdc_request_type r;
      tdc_result_type  predicted;
      tdc_result_type  want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = requests_in_flight.pop_front();
         predicted = compute_lookup_result(r);
         if (r.has_fixed) begin
            predicted.read_value = r.fixed_value;
            predicted.in_range = 1'b0;
         end
         expected_results.push_back(predicted);
         mode_counts[r.mode]++;
         if (r.fine_code >= FINE_ENTRIES &&
             (r.mode == MODE_WR_ENTRY || r.mode == MODE_RD_ENTRY || r.mode == MODE_TIME))
            clamped_codes++;
         if (r.mode == MODE_TIME && predicted.in_range) times_in_range++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: read_value %0d, in_range %0d",
                   rsp_chan.read_value, rsp_chan.in_range);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d",
                      want.read_value, rsp_chan.read_value);
               mismatches++;
            end
            if (rsp_chan.in_range !== want.in_range) begin
               $error("in_range: expected %0d, actual %0d", want.in_range, rsp_chan.in_range);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL tdc_fine_time_calibration_lut");
         $finish;
      end
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.mode        = '0;
      req_chan.channel     = '0;
      req_chan.tac         = '0;
      req_chan.side        = 1'b0;
      req_chan.fine_code   = '0;
      req_chan.coarse      = '0;
      req_chan.write_value = '0;
      foreach (offset_store[i]) offset_store[i] = '0;
      foreach (mode_counts[i]) mode_counts[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      for (int i = 0; i < ROW_COUNT; i++) drive_request(DIRECTED_ROWS[i]);
      wait_all_results();

      // Random traffic with idling on both sides
      repeat (450) drive_request(make_random_request());
      wait_all_results();

      // Back-to-back stretch, no idling anywhere
      send_idle = 1'b0;
      recv_idle = 1'b0;
      repeat (200) drive_request(make_random_request());
      wait_all_results();

      // Hold the result side off while requests keep coming
      recv_idle = 1'b1;
      rsp_hold_cycles = LONG_HOLD;
      repeat (60) drive_request(make_random_request());
      wait_all_results();

      send_idle = 1'b1;
      repeat (400) drive_request(make_random_request());
      wait_all_results();

      $display("covered %0d entry writes, %0d offset writes, %0d entry reads, %0d offset reads",
               mode_counts[MODE_WR_ENTRY], mode_counts[MODE_WR_OFFSET],
               mode_counts[MODE_RD_ENTRY], mode_counts[MODE_RD_OFFSET]);
      $display("and %0d time lookups (%0d in range), %0d clamped codes, %0d undecoded modes",
               mode_counts[MODE_TIME], times_in_range, clamped_codes,
               mode_counts[MODE_SPARE_FIRST] + mode_counts[MODE_SPARE_MID] +
               mode_counts[MODE_SPARE_LAST]);
      if (mismatches == 0) begin
         $display("PASS tdc_fine_time_calibration_lut");
      end else begin
         $display("FAIL tdc_fine_time_calibration_lut");
      end
      $finish;
   end

endmodule
